/* src/snt_pkg.sv */
// ----------------------------------------------------------------------------
// snt_pkg
// Shared constants, types and the arctangent table for the texture
// coordinate generator.
// ----------------------------------------------------------------------------
`default_nettype none
package snt_pkg;

    localparam int CordicStagesDefault = 16;
    localparam int TableLen = 24;
    localparam int DataW = 32;
    localparam int AngleW = 32;
    localparam logic [16:0] InvGainQ16 = 17'd39797;
    localparam logic [15:0] SeamLimit = 16'd65470;
    localparam logic [1:0] SeamSector = 2'd2;

    typedef logic signed [DataW-1:0] t_data;
    typedef logic [AngleW-1:0] t_angle;

    function automatic t_angle atan_lut(input int idx);
        t_angle v;
        v = '0;
        case (idx)
            0: v = 32'h20000000;
            1: v = 32'h12E4051E;
            2: v = 32'h09FB385B;
            3: v = 32'h051111D4;
            4: v = 32'h028B0D43;
            5: v = 32'h0145D7E1;
            6: v = 32'h00A2F61E;
            7: v = 32'h00517C55;
            8: v = 32'h0028BE53;
            9: v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* src/sphere_normal_texcoord_top.sv */
// ----------------------------------------------------------------------------
// sphere_normal_texcoord_top
// Equirectangular texture coordinates from a unit surface normal.
// ----------------------------------------------------------------------------
// An item (nx, ny, nz, sector) is taken at a clock edge with start high;
// busy is always low, so one item may enter every cycle.
// Each result appears on o_tex_s and o_tex_t for one cycle with o_strobe
// high. Results come out in input order.
// The path runs through two pipelined CORDIC vectoring passes of one stage
// per iteration plus an input stage each, one radius scaling stage and one
// output mapping stage.
// Throughput is one item per cycle.
// The sky_mode register is written through i_cfg_valid / o_cfg_ready and
// is read at the output stage; write it only while no item is in flight.
// Synchronous reset clears all valid bits and sky_mode.
// The receiver cannot stall; results are presented once and not held.
// ----------------------------------------------------------------------------
`default_nettype none
module sphere_normal_texcoord_top #(
    parameter int CORDIC_STAGES = snt_pkg::CordicStagesDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_nx,
    input  wire logic signed [15:0] i_ny,
    input  wire logic signed [15:0] i_nz,
    input  wire logic [1:0]         i_sector,
    output logic                    o_strobe,
    output logic [15:0]             o_tex_s,
    output logic [15:0]             o_tex_t,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_data
);
    import snt_pkg::*;

    logic        r_sky;
    logic        w_v1;
    t_data       w_mag;
    t_angle      w_az;
    logic [17:0] w_side1;
    logic        w_v2;
    t_data       w_r;
    t_data       w_zc;
    logic [15:0] w_s;
    logic        w_v3;
    t_data       w_unused_x;
    t_angle      w_elev;
    logic [15:0] w_side3;
    logic signed [33:0] w_e;
    logic signed [33:0] w_t;
    logic        r_strobe;
    logic [15:0] r_s;
    logic [15:0] r_t;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    snt_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(18)) u_az (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start),
        .i_x(t_data'({{8{i_nx[15]}}, i_nx, 8'd0})),
        .i_y(t_data'({{8{i_ny[15]}}, i_ny, 8'd0})),
        .i_side({i_sector, i_nz}),
        .o_valid(w_v1), .o_x(w_mag), .o_z(w_az), .o_side(w_side1)
    );

    snt_radius u_rad (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_v1),
        .i_mag(w_mag), .i_az(w_az), .i_sector(w_side1[17:16]),
        .i_nz(w_side1[15:0]),
        .o_valid(w_v2), .o_r(w_r), .o_zc(w_zc), .o_s(w_s)
    );

    snt_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(16)) u_el (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_v2),
        .i_x(w_r), .i_y(w_zc), .i_side(w_s),
        .o_valid(w_v3), .o_x(w_unused_x), .o_z(w_elev), .o_side(w_side3)
    );

    always_comb begin
        w_e = 34'(signed'(w_elev));
        if (r_sky) begin
            w_t = 34'sd16384 + ((w_e + 34'sd32768) >>> 16);
            if (w_t > 34'sd32768) w_t = 34'sd32768;
        end else begin
            w_t = 34'sd8192 + ((w_e + 34'sd65536) >>> 17);
            if (w_t > 34'sd16384) w_t = 34'sd16384;
        end
        if (w_t < 0) w_t = '0;
        if (w_unused_x[0] && 1'b0) w_t = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sky    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_sky <= i_cfg_data;
            r_strobe <= w_v3;
        end
        r_s <= w_side3;
        r_t <= w_t[15:0];
    end

    assign o_strobe = r_strobe;
    assign o_tex_s  = r_s;
    assign o_tex_t  = r_t;
endmodule
`default_nettype wire

/* src/snt_cordic.sv */
// ----------------------------------------------------------------------------
// snt_cordic
// Pipelined CORDIC vectoring unit, one register stage per iteration plus
// an input stage, carrying a side payload alongside.
// ----------------------------------------------------------------------------
`default_nettype none
module snt_cordic #(
    parameter int STAGES = snt_pkg::CordicStagesDefault,
    parameter int SIDE_W = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire snt_pkg::t_data        i_x,
    input  wire snt_pkg::t_data        i_y,
    input  wire logic [SIDE_W-1:0]     i_side,
    output logic                       o_valid,
    output snt_pkg::t_data             o_x,
    output snt_pkg::t_angle            o_z,
    output logic [SIDE_W-1:0]          o_side
);
    import snt_pkg::*;

    localparam int N = (STAGES < TableLen) ? STAGES : TableLen;

    logic        r_v [N+1];
    t_data       r_x [N+1];
    t_data       r_y [N+1];
    t_angle      r_z [N+1];
    logic        r_zero [N+1];
    logic [SIDE_W-1:0] r_side [N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_side[0] <= i_side;
        r_zero[0] <= (i_x == '0) && (i_y == '0);
        if (i_x < 0) begin
            r_x[0] <= -i_x;
            r_y[0] <= -i_y;
            r_z[0] <= t_angle'(32'h80000000);
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= '0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
            r_side[g+1] <= r_side[g];
            r_zero[g+1] <= r_zero[g];
            if (r_y[g] > 0) begin
                r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] + atan_lut(g);
            end else begin
                r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] - atan_lut(g);
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_x     = r_zero[N] ? '0 : r_x[N];
    assign o_z     = r_zero[N] ? '0 : r_z[N];
    assign o_side  = r_side[N];
endmodule
`default_nettype wire

/* src/snt_radius.sv */
// ----------------------------------------------------------------------------
// snt_radius
// Gain correction of the planar radius and azimuth to tex_s conversion,
// one register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module snt_radius (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire snt_pkg::t_data   i_mag,
    input  wire snt_pkg::t_angle  i_az,
    input  wire logic [1:0]       i_sector,
    input  wire logic [15:0]      i_nz,
    output logic                  o_valid,
    output snt_pkg::t_data        o_r,
    output snt_pkg::t_data        o_zc,
    output logic [15:0]           o_s
);
    import snt_pkg::*;

    logic signed [49:0] w_prod;
    logic [AngleW-1:0]  w_az_r;
    logic [15:0]        w_s;
    logic               r_v;
    t_data              r_r;
    t_data              r_zc;
    logic [15:0]        r_s;

    assign w_prod = $signed(i_mag) * $signed({1'b0, InvGainQ16}) + 50'sd32768;
    assign w_az_r = i_az + 32'd32768;
    assign w_s    = w_az_r[31:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_valid;
        end
        r_r  <= t_data'(w_prod >>> 16);
        r_zc <= t_data'({{8{i_nz[15]}}, i_nz, 8'd0});
        r_s  <= (i_sector == SeamSector && w_s > SeamLimit) ? 16'd0 : w_s;
    end

    assign o_valid = r_v;
    assign o_r     = r_r;
    assign o_zc    = r_zc;
    assign o_s     = r_s;
endmodule
`default_nettype wire
